// ===== rtl/core/keyed_power_of_two_range_allocator_unit_macros.svh =====
// Assertion macros shared by the range allocator modules.
`ifndef KEYED_POWER_OF_TWO_RANGE_ALLOCATOR_UNIT_MACROS_SVH
`define KEYED_POWER_OF_TWO_RANGE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define KPRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define KPRA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define KPRA_ASSERT(lbl, prop, msg)
`define KPRA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/kpra_pkg.sv =====
// Types, widths and codes shared by the range allocator modules.
package kpra_pkg;

  localparam int unsigned START_W   = 28;
  localparam int unsigned END_W     = 29;
  localparam int unsigned KEY_W     = 48;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned IDX_W     = 17;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned GROW_W    = 25;
  localparam int unsigned CFG_W     = 29;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [END_W-1:0]  RESET_POOL   = 29'd1048576;
  localparam logic [GROW_W-1:0] RESET_GROWTH = 25'd1048576;
  localparam logic [CFG_W-1:0]  RESET_LIMIT  = 29'd16777216;
  localparam logic [END_W-1:0]  ADDR_SPAN    = 29'h1000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT  = 2'd1;

  localparam logic [ST_W-1:0] ST_NEW        = 3'd0;
  localparam logic [ST_W-1:0] ST_REUSED     = 3'd1;
  localparam logic [ST_W-1:0] ST_GROWN      = 3'd2;
  localparam logic [ST_W-1:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd4;
  localparam logic [ST_W-1:0] ST_FREE_FULL  = 3'd5;
  localparam logic [ST_W-1:0] ST_LIMIT      = 3'd6;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [END_W-1:0]   stop;
  } free_ent_t;

  typedef struct packed {
    logic            accept;
    logic            load;
    logic            oscan_run;
    logic            fsearch_start;
    logic            fsearch_run;
    logic            take_pick;
    logic            take_grow;
    logic            split_init;
    logic            split_step;
    logic            split_write;
    logic            cmp_init;
    logic            cmp_rd;
    logic            cmp_wr;
    logic            old_write;
    logic            commit;
    logic            emit;
    logic [ST_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic oscan_done;
    logic hit;
    logic reuse_ok;
    logic empty_found;
    logic append_full;
    logic fsearch_done;
    logic found;
    logic grow_ok;
    logic split_done;
    logic split_fits;
    logic pick_real;
    logic cmp_more;
    logic need_old;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/kpra_ctrl.sv =====
// Request sequencer of the range allocator.
`include "keyed_power_of_two_range_allocator_unit_macros.svh"

module kpra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kpra_pkg::stat_t stat_i,
  output kpra_pkg::cmd_t  cmd_o
);
  import kpra_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LOAD    = 5'd1;
  localparam logic [4:0] S_CHK     = 5'd2;
  localparam logic [4:0] S_OSCAN   = 5'd3;
  localparam logic [4:0] S_OCHECK  = 5'd4;
  localparam logic [4:0] S_FSEARCH = 5'd5;
  localparam logic [4:0] S_DECIDE  = 5'd6;
  localparam logic [4:0] S_SINIT   = 5'd7;
  localparam logic [4:0] S_PCOUNT  = 5'd8;
  localparam logic [4:0] S_PCHECK  = 5'd9;
  localparam logic [4:0] S_CMP     = 5'd10;
  localparam logic [4:0] S_CMPW    = 5'd11;
  localparam logic [4:0] S_OLD     = 5'd12;
  localparam logic [4:0] S_PINIT   = 5'd13;
  localparam logic [4:0] S_PWRITE  = 5'd14;
  localparam logic [4:0] S_COMMIT  = 5'd15;
  localparam logic [4:0] S_EMIT    = 5'd16;

  logic [4:0]      state_q, state_d;
  logic [ST_W-1:0] code_q, code_d;

  always_comb begin
    cmd_o      = '0;
    cmd_o.code = code_q;
    state_d    = state_q;
    code_d     = code_q;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        if (stat_i.too_large) begin
          code_d  = ST_TOO_LARGE;
          state_d = S_EMIT;
        end else begin
          state_d = S_OSCAN;
        end
      end
      S_OSCAN: begin
        cmd_o.oscan_run = 1'b1;
        if (stat_i.oscan_done) state_d = S_OCHECK;
      end
      S_OCHECK: begin
        priority if (stat_i.reuse_ok) begin
          code_d  = ST_REUSED;
          state_d = S_EMIT;
        end else if (!stat_i.hit && !stat_i.empty_found) begin
          code_d  = ST_TABLE_FULL;
          state_d = S_EMIT;
        end else if (stat_i.append_full) begin
          code_d  = ST_FREE_FULL;
          state_d = S_EMIT;
        end else begin
          cmd_o.fsearch_start = 1'b1;
          state_d             = S_FSEARCH;
        end
      end
      S_FSEARCH: begin
        cmd_o.fsearch_run = 1'b1;
        if (stat_i.fsearch_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (stat_i.found) begin
          cmd_o.take_pick = 1'b1;
          code_d          = ST_NEW;
          state_d         = S_SINIT;
        end else if (stat_i.grow_ok) begin
          cmd_o.take_grow = 1'b1;
          code_d          = ST_GROWN;
          state_d         = S_SINIT;
        end else begin
          code_d  = ST_LIMIT;
          state_d = S_EMIT;
        end
      end
      S_SINIT: begin
        cmd_o.split_init = 1'b1;
        state_d          = S_PCOUNT;
      end
      S_PCOUNT: begin
        if (stat_i.split_done) state_d = S_PCHECK;
        else cmd_o.split_step = 1'b1;
      end
      S_PCHECK: begin
        priority if (!stat_i.split_fits) begin
          code_d  = ST_FREE_FULL;
          state_d = S_EMIT;
        end else if (stat_i.pick_real) begin
          cmd_o.cmp_init = 1'b1;
          state_d        = S_CMP;
        end else begin
          state_d = S_OLD;
        end
      end
      S_CMP: begin
        if (stat_i.cmp_more) begin
          cmd_o.cmp_rd = 1'b1;
          state_d      = S_CMPW;
        end else begin
          state_d = S_OLD;
        end
      end
      S_CMPW: begin
        cmd_o.cmp_wr = 1'b1;
        state_d      = S_CMP;
      end
      S_OLD: begin
        cmd_o.old_write = stat_i.need_old;
        state_d         = S_PINIT;
      end
      S_PINIT: begin
        cmd_o.split_init = 1'b1;
        state_d          = S_PWRITE;
      end
      S_PWRITE: begin
        if (stat_i.split_done) state_d = S_COMMIT;
        else cmd_o.split_write = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_NEW;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  `KPRA_ASSERT(a_emit_room, cmd_o.emit |-> stat_i.out_free, "result emitted over a held one")
  `KPRA_ASSERT(a_commit_then_emit, state_q == S_COMMIT |=> state_q == S_EMIT,
               "commit not followed by result")
  `KPRA_ASSERT_NEVER(a_accept_busy, cmd_o.accept && (state_q != S_IDLE), "accept while busy")

endmodule

// ===== rtl/core/kpra_dp.sv =====
// Datapath of the range allocator: owner table, free list, split and result.
`include "keyed_power_of_two_range_allocator_unit_macros.svh"

module kpra_dp #(
  parameter int unsigned FREE_DEPTH  = 64,
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned MIN_GRANULE = 64,
  parameter int unsigned MAX_GRANULE = 32768
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kpra_pkg::cmd_t                      cmd_i,
  output kpra_pkg::stat_t                     stat_o,
  input  logic                                cfg_we_i,
  input  logic [kpra_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kpra_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic signed [15:0]                  chunk_x_i,
  input  logic signed [15:0]                  chunk_y_i,
  input  logic signed [15:0]                  chunk_z_i,
  input  logic [kpra_pkg::CNT_W-1:0]          vertex_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kpra_pkg::START_W-1:0]        start_pos_o,
  output logic [kpra_pkg::SIZE_W-1:0]         range_size_o,
  output logic [kpra_pkg::IDX_W-1:0]          index_count_o,
  output logic [kpra_pkg::ST_W-1:0]           status_o,
  output logic [kpra_pkg::END_W-1:0]          pool_size_o
);
  import kpra_pkg::*;

  localparam int unsigned FAW = $clog2(FREE_DEPTH);
  localparam int unsigned FCW = $clog2(FREE_DEPTH + 1);
  localparam int unsigned TW  = $clog2(TABLE_DEPTH);
  localparam int unsigned GW  = $clog2(MAX_GRANULE) + 1;
  localparam int unsigned OW  = KEY_W + START_W + GW;

  // configuration and persistent state
  logic [GROW_W-1:0]      growth_q;
  logic [CFG_W-1:0]       limit_q;
  logic [END_W-1:0]       pool_q;
  logic [FCW-1:0]         fc_q;
  logic                   fresh_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   out_valid_q;

  // memories
  free_ent_t        fmem [FREE_DEPTH];
  logic [OW-1:0]    omem [TABLE_DEPTH];
  free_ent_t        fr_q;
  logic             fz_q;
  logic [OW-1:0]    od_q;

  // request
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] cnt_q;
  logic [GW-1:0]    g_q;
  logic             tl_q;

  // owner scan
  logic [TW:0]      oa_q;
  logic [TW-1:0]    oi_q;
  logic             ov_q, hit_q, emp_q, olast_q;
  logic [TW-1:0]    hidx_q, eidx_q;
  logic [START_W-1:0] hs_q;
  logic [GW-1:0]    hsz_q;

  // free search
  logic [FCW-1:0]   nn_q, fa_q, fi_q, pick_q;
  logic             fv_q, exact_q, best_q, flast_q;
  free_ent_t        pe_q;
  logic [END_W-1:0] bsz_q;

  // split and commit
  logic [START_W-1:0] s_q;
  logic [END_W-1:0]   e_q, np_q, pos_q, rem_q;
  logic [END_W:0]     cur_q;
  logic [FCW-1:0]     n2_q, wp_q, k_q;
  logic [FCW:0]       pc_q;

  // result
  logic [START_W-1:0] o_start_q;
  logic [SIZE_W-1:0]  o_size_q;
  logic [IDX_W-1:0]   o_idx_q;
  logic [ST_W-1:0]    o_status_q;
  logic [END_W-1:0]   o_pool_q;

  // granule rounding
  logic [CNT_W:0]   cm1;
  logic [4:0]       msb;
  logic [CNT_W+1:0] pw;
  logic             tl_c;
  logic [GW-1:0]    g_c;

  always_comb begin
    cm1 = {1'b0, cnt_q} - 1'b1;
    msb = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (cm1[i]) msb = 5'(i);
    end
    pw   = (CNT_W + 2)'(1) << (msb + 5'd1);
    tl_c = 32'(cnt_q) > MAX_GRANULE;
    if (tl_c) g_c = GW'(MAX_GRANULE);
    else if (32'(cnt_q) <= MIN_GRANULE) g_c = GW'(MIN_GRANULE);
    else g_c = GW'(pw);
  end

  // derived values
  free_ent_t        fent, old_ent, cand;
  logic [END_W-1:0] cand_sz, g_ext, lim, piece;
  logic [END_W:0]   cur_ext;
  logic             found;
  logic [FCW-1:0]   kp1, fcm1, old_addr;
  logic [TW-1:0]    slot;
  logic             f_we;
  logic [FAW-1:0]   f_waddr, f_raddr;
  free_ent_t        f_wdata;
  logic             out_free;

  always_comb begin
    fent          = fz_q ? free_ent_t'{start: '0, stop: RESET_POOL} : fr_q;
    old_ent.start = hs_q;
    old_ent.stop  = {1'b0, hs_q} + END_W'(hsz_q);
    cand          = (fi_q == fc_q) ? old_ent : fent;
    cand_sz       = cand.stop - {1'b0, cand.start};
    g_ext         = END_W'(g_q);
    lim           = (limit_q < ADDR_SPAN) ? limit_q : ADDR_SPAN;
    cur_ext       = cur_q;
    piece         = (cur_ext < {1'b0, rem_q}) ? cur_q[END_W-1:0] : rem_q;
    found         = exact_q || best_q;
    kp1           = FCW'(k_q + 1'b1);
    fcm1          = FCW'(fc_q - 1'b1);
    old_addr      = found ? fcm1 : fc_q;
    slot          = hit_q ? hidx_q : eidx_q;
    out_free      = !out_valid_q || !out_stall_i;

    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = fent;
    priority if (cmd_i.cmp_wr) begin
      f_we    = 1'b1;
      f_waddr = k_q[FAW-1:0];
    end else if (cmd_i.old_write) begin
      f_we    = 1'b1;
      f_waddr = old_addr[FAW-1:0];
      f_wdata = old_ent;
    end else if (cmd_i.split_write) begin
      f_we          = 1'b1;
      f_waddr       = wp_q[FAW-1:0];
      f_wdata.start = pos_q[START_W-1:0];
      f_wdata.stop  = pos_q + piece;
    end
    f_raddr = cmd_i.cmp_rd ? kp1[FAW-1:0] : fa_q[FAW-1:0];
  end

  always_comb begin
    stat_o              = '0;
    stat_o.too_large    = tl_q;
    stat_o.oscan_done   = hit_q || olast_q;
    stat_o.hit          = hit_q;
    stat_o.reuse_ok     = hit_q && (hsz_q >= g_q);
    stat_o.empty_found  = emp_q;
    stat_o.append_full  = hit_q && (32'(fc_q) >= FREE_DEPTH);
    stat_o.fsearch_done = (nn_q == '0) || exact_q || flast_q;
    stat_o.found        = found;
    stat_o.grow_ok      = (32'(growth_q) >= 32'(g_q)) &&
                          (32'(pool_q) + 32'(growth_q) <= 32'(lim));
    stat_o.split_done   = (rem_q == '0);
    stat_o.split_fits   = (32'(n2_q) + 32'(pc_q)) <= FREE_DEPTH;
    stat_o.pick_real    = found && (pick_q != fc_q);
    stat_o.cmp_more     = (32'(k_q) + 1) < 32'(fc_q);
    stat_o.need_old     = hit_q && !(found && (pick_q == fc_q));
    stat_o.out_free     = out_free;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    fr_q <= fmem[f_raddr];
    if (cmd_i.commit) omem[slot] <= {key_q, s_q, g_q};
    od_q <= omem[oa_q[TW-1:0]];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      growth_q    <= RESET_GROWTH;
      limit_q     <= RESET_LIMIT;
      pool_q      <= RESET_POOL;
      fc_q        <= FCW'(1);
      fresh_q     <= 1'b1;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      fz_q        <= 1'b0;
      ov_q        <= 1'b0;
      hit_q       <= 1'b0;
      emp_q       <= 1'b0;
      olast_q     <= 1'b0;
      fv_q        <= 1'b0;
      exact_q     <= 1'b0;
      best_q      <= 1'b0;
      flast_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GROWTH_STEP: growth_q <= cfg_wdata_i[GROW_W-1:0];
          CFG_POOL_LIMIT:  limit_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (f_we && (f_waddr == '0)) fresh_q <= 1'b0;
      fz_q <= fresh_q && (f_raddr == '0);

      // owner scan: one read issued per cycle, checked in the cycle after
      ov_q <= cmd_i.oscan_run && (32'(oa_q) < TABLE_DEPTH);
      if (cmd_i.load) begin
        hit_q   <= 1'b0;
        emp_q   <= 1'b0;
        olast_q <= 1'b0;
      end else if (ov_q && !hit_q && !olast_q) begin
        if (valid_q[oi_q]) begin
          if (od_q[OW-1 -: KEY_W] == key_q) hit_q <= 1'b1;
        end else begin
          emp_q <= 1'b1;
        end
        if (32'(oi_q) == TABLE_DEPTH - 1) olast_q <= 1'b1;
      end

      // free search: first exact fit wins, else smallest larger entry
      fv_q <= cmd_i.fsearch_run && (fa_q < nn_q);
      if (cmd_i.fsearch_start) begin
        exact_q <= 1'b0;
        best_q  <= 1'b0;
        flast_q <= 1'b0;
      end else if (fv_q && !exact_q && !flast_q) begin
        if (cand_sz == g_ext) exact_q <= 1'b1;
        else if ((cand_sz > g_ext) && (cand_sz < bsz_q)) best_q <= 1'b1;
        if (fi_q == FCW'(nn_q - 1'b1)) flast_q <= 1'b1;
      end

      if (cmd_i.commit) begin
        valid_q[slot] <= 1'b1;
        pool_q        <= np_q;
        fc_q          <= wp_q;
      end

      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= {chunk_z_i, chunk_y_i, chunk_x_i};
      cnt_q <= vertex_count_i;
    end
    if (cmd_i.load) begin
      g_q  <= g_c;
      tl_q <= tl_c;
      oa_q <= '0;
    end else if (cmd_i.oscan_run && (32'(oa_q) < TABLE_DEPTH)) begin
      oa_q <= oa_q + 1'b1;
    end
    oi_q <= oa_q[TW-1:0];
    if (ov_q && !hit_q && !olast_q) begin
      if (valid_q[oi_q]) begin
        if (od_q[OW-1 -: KEY_W] == key_q) begin
          hidx_q <= oi_q;
          hs_q   <= od_q[GW +: START_W];
          hsz_q  <= od_q[GW-1:0];
        end
      end else if (!emp_q) begin
        eidx_q <= oi_q;
      end
    end

    if (cmd_i.fsearch_start) begin
      nn_q  <= FCW'(fc_q + FCW'(hit_q));
      fa_q  <= '0;
      bsz_q <= '1;
    end else if (cmd_i.fsearch_run && (fa_q < nn_q)) begin
      fa_q <= fa_q + 1'b1;
    end
    fi_q <= fa_q;
    if (fv_q && !exact_q && !flast_q) begin
      if (cand_sz == g_ext) begin
        pick_q <= fi_q;
        pe_q   <= cand;
      end else if ((cand_sz > g_ext) && (cand_sz < bsz_q)) begin
        pick_q <= fi_q;
        pe_q   <= cand;
        bsz_q  <= cand_sz;
      end
    end

    if (cmd_i.take_pick) begin
      s_q  <= pe_q.start;
      e_q  <= pe_q.stop;
      np_q <= pool_q;
      n2_q <= FCW'(nn_q - 1'b1);
    end else if (cmd_i.take_grow) begin
      s_q  <= pool_q[START_W-1:0];
      e_q  <= END_W'(pool_q + END_W'(growth_q));
      np_q <= END_W'(pool_q + END_W'(growth_q));
      n2_q <= nn_q;
    end

    // split remainder into doubling pieces
    if (cmd_i.split_init) begin
      pos_q <= {1'b0, s_q} + g_ext;
      rem_q <= e_q - ({1'b0, s_q} + g_ext);
      cur_q <= (END_W + 1)'(g_q);
      pc_q  <= '0;
      wp_q  <= n2_q;
    end else if (cmd_i.split_step || cmd_i.split_write) begin
      pos_q <= pos_q + piece;
      rem_q <= rem_q - piece;
      cur_q <= cur_q << 1;
      pc_q  <= pc_q + 1'b1;
      if (cmd_i.split_write) wp_q <= wp_q + 1'b1;
    end

    if (cmd_i.cmp_init) k_q <= pick_q;
    else if (cmd_i.cmp_wr) k_q <= kp1;

    if (cmd_i.emit) begin
      o_idx_q    <= IDX_W'(cnt_q) + IDX_W'(cnt_q >> 1);
      o_status_q <= cmd_i.code;
      o_pool_q   <= pool_q;
      priority if (cmd_i.code == ST_REUSED) begin
        o_start_q <= hs_q;
        o_size_q  <= SIZE_W'(hsz_q);
      end else if ((cmd_i.code == ST_NEW) || (cmd_i.code == ST_GROWN)) begin
        o_start_q <= s_q;
        o_size_q  <= SIZE_W'(g_q);
      end else begin
        o_start_q <= '0;
        o_size_q  <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign start_pos_o   = o_start_q;
  assign range_size_o  = o_size_q;
  assign index_count_o = o_idx_q;
  assign status_o      = o_status_q;
  assign pool_size_o   = o_pool_q;

  `KPRA_ASSERT(a_fc_bound, 32'(fc_q) <= FREE_DEPTH, "free count beyond depth")
  `KPRA_ASSERT(a_commit_split, cmd_i.commit |-> (rem_q == '0), "commit with split pending")
  `KPRA_ASSERT(a_piece_room, cmd_i.split_write |-> (32'(wp_q) < FREE_DEPTH),
               "piece written past free list end")

endmodule

// ===== rtl/core/keyed_power_of_two_range_allocator_unit.sv =====
// Top level of the keyed power-of-two range allocator.
//
// Usage: each input request carries an owner key (chunk_x/y/z) and a vertex
// count; it is taken when in_valid_i is high and in_stall_o is low. One result
// comes back per request on the output channel, taken when out_valid_o is high
// and out_stall_i is low. The block works on one request at a time.
// A request walks the owner table (one entry per cycle through its read port),
// then the free list, moves entries up and writes the split pieces. A reuse
// hit ends after the scan; an oversize count ends without a scan.
// A held result sits in the output register while the next request is taken;
// a stalled receiver only holds the block once a second result is ready.
// Reset empties the owner table, sets the pool to 1048576 slots with one free
// entry spanning it, and restores growth_step and pool_limit to their defaults.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once
// and are meant for idle periods only.
module keyed_power_of_two_range_allocator_unit #(
  parameter int unsigned FREE_DEPTH  = 64,
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned MIN_GRANULE = 64,
  parameter int unsigned MAX_GRANULE = 32768
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kpra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kpra_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             chunk_x_i,
  input  logic signed [15:0]             chunk_y_i,
  input  logic signed [15:0]             chunk_z_i,
  input  logic [kpra_pkg::CNT_W-1:0]     vertex_count_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kpra_pkg::START_W-1:0]   start_pos_o,
  output logic [kpra_pkg::SIZE_W-1:0]    range_size_o,
  output logic [kpra_pkg::IDX_W-1:0]     index_count_o,
  output logic [kpra_pkg::ST_W-1:0]      status_o,
  output logic [kpra_pkg::END_W-1:0]     pool_size_o
);
  import kpra_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  kpra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kpra_dp #(
    .FREE_DEPTH  (FREE_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH),
    .MIN_GRANULE (MIN_GRANULE),
    .MAX_GRANULE (MAX_GRANULE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .chunk_x_i      (chunk_x_i),
    .chunk_y_i      (chunk_y_i),
    .chunk_z_i      (chunk_z_i),
    .vertex_count_i (vertex_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .start_pos_o    (start_pos_o),
    .range_size_o   (range_size_o),
    .index_count_o  (index_count_o),
    .status_o       (status_o),
    .pool_size_o    (pool_size_o)
  );

endmodule

// ===== tb/tb_keyed_power_of_two_range_allocator_unit.sv =====
// Testbench for the keyed power-of-two range allocator: directed and random requests.
module tb_keyed_power_of_two_range_allocator_unit;
  import kpra_pkg::*;

  localparam int unsigned FREE_N   = 64;
  localparam int unsigned OWNER_N  = 256;
  localparam int unsigned GRAN_MIN = 64;
  localparam int unsigned GRAN_MAX = 32768;
  localparam int unsigned STALL_PCT = 12;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES = 800;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  // One granted range as the output channel carries it.
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic [IDX_W-1:0]   idx;
    logic [ST_W-1:0]    status;
    logic [END_W-1:0]   pool;
  } grant_t;

  // One row of the directed plan; typed rows carry a hand-written grant.
  typedef struct packed {
    logic [15:0]        x;
    logic [15:0]        y;
    logic [15:0]        z;
    logic [CNT_W-1:0]   cnt;
    logic               typed;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic [ST_W-1:0]    status;
    logic [END_W-1:0]   pool;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        chunk_x = '0;
  logic [15:0]        chunk_y = '0;
  logic [15:0]        chunk_z = '0;
  logic [CNT_W-1:0]   vertex_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [START_W-1:0] start_pos;
  logic [SIZE_W-1:0]  range_size;
  logic [IDX_W-1:0]   index_count;
  logic [ST_W-1:0]    status;
  logic [END_W-1:0]   pool_size;

  keyed_power_of_two_range_allocator_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .chunk_x_i      (chunk_x),
    .chunk_y_i      (chunk_y),
    .chunk_z_i      (chunk_z),
    .vertex_count_i (vertex_count),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .start_pos_o    (start_pos),
    .range_size_o   (range_size),
    .index_count_o  (index_count),
    .status_o       (status),
    .pool_size_o    (pool_size)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Allocator mirror: registers, free list and owner table.
  logic [GROW_W-1:0]  m_growth;
  logic [CFG_W-1:0]   m_limit;
  logic [START_W-1:0] m_fstart [FREE_N];
  logic [END_W-1:0]   m_fend   [FREE_N];
  int                 m_fcount;
  bit                 m_ovalid [OWNER_N];
  logic [KEY_W-1:0]   m_okey   [OWNER_N];
  logic [START_W-1:0] m_ostart [OWNER_N];
  logic [SIZE_W-1:0]  m_osize  [OWNER_N];
  logic [END_W-1:0]   m_pool;

  grant_t pending_grants [$];
  int     fail_count = 0;
  int     accepted_in = 0;
  bit     quiet = 1'b0;
  bit     in_fire;
  bit     out_fire;

  // Compute the grant for one request and update the mirror on success.
  function automatic grant_t allocate(input logic [KEY_W-1:0] key, input logic [CNT_W-1:0] cnt);
    grant_t r;
    logic [16:0] g;
    int hit, empty, n, exact, best, pick, slot;
    logic [29:0] best_sz, sz, s, e, pos, rem, cur, piece, lim, new_pool;
    logic [START_W-1:0] ws [FREE_N];
    logic [END_W-1:0]   we [FREE_N];
    logic [ST_W-1:0] st;
    r.idx = {1'b0, cnt} + {2'b0, cnt[15:1]};
    r.start = '0;
    r.size = '0;
    r.pool = m_pool;
    g = 17'(GRAN_MIN);
    while (g < {1'b0, cnt} && g * 2 <= 17'(GRAN_MAX)) g = g * 2;
    if ({1'b0, cnt} > g) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    hit = -1;
    empty = -1;
    for (int i = 0; i < OWNER_N; i++) begin
      if (m_ovalid[i]) begin
        if (hit < 0 && m_okey[i] == key) hit = i;
      end else if (empty < 0) begin
        empty = i;
      end
    end
    if (hit >= 0 && {1'b0, m_osize[hit]} >= g) begin
      r.start = m_ostart[hit];
      r.size = m_osize[hit];
      r.status = ST_REUSED;
      return r;
    end
    if (hit < 0 && empty < 0) begin
      r.status = ST_TABLE_FULL;
      return r;
    end
    n = m_fcount;
    ws = m_fstart;
    we = m_fend;
    // Return the owner's old range to the tail of the list first.
    if (hit >= 0) begin
      if (n >= FREE_N) begin
        r.status = ST_FREE_FULL;
        return r;
      end
      ws[n] = m_ostart[hit];
      we[n] = {1'b0, m_ostart[hit]} + m_osize[hit];
      n++;
    end
    exact = -1;
    best = -1;
    best_sz = '1;
    for (int k = 0; k < n; k++) begin
      sz = we[k] - ws[k];
      if (sz == g) begin
        exact = k;
        break;
      end
      if (sz > g && sz < best_sz) begin
        best = k;
        best_sz = sz;
      end
    end
    new_pool = m_pool;
    if (exact >= 0 || best >= 0) begin
      pick = exact >= 0 ? exact : best;
      s = ws[pick];
      e = we[pick];
      for (int k = pick; k + 1 < n; k++) begin
        ws[k] = ws[k + 1];
        we[k] = we[k + 1];
      end
      n--;
      st = ST_NEW;
    end else begin
      lim = m_limit < ADDR_SPAN ? m_limit : ADDR_SPAN;
      if (m_growth < g || 30'(m_pool) + m_growth > lim) begin
        r.status = ST_LIMIT;
        return r;
      end
      s = m_pool;
      e = 30'(m_pool) + m_growth;
      new_pool = e;
      st = ST_GROWN;
    end
    // Split the remainder into doubling pieces, clipping the last.
    pos = s + g;
    rem = e - pos;
    cur = g;
    while (rem > 0) begin
      piece = cur < rem ? cur : rem;
      if (n >= FREE_N) begin
        r.status = ST_FREE_FULL;
        return r;
      end
      ws[n] = pos;
      we[n] = pos + piece;
      n++;
      rem -= piece;
      pos += piece;
      cur = cur * 2;
    end
    m_fstart = ws;
    m_fend = we;
    m_fcount = n;
    m_pool = new_pool;
    slot = hit >= 0 ? hit : empty;
    m_ovalid[slot] = 1'b1;
    m_okey[slot] = key;
    m_ostart[slot] = s;
    m_osize[slot] = g[15:0];
    r.start = s;
    r.size = g[15:0];
    r.status = st;
    r.pool = m_pool;
    return r;
  endfunction

  // Offer one request, hold it until taken, then record its grant.
  task automatic push_request(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                              input logic [CNT_W-1:0] cnt, input bit typed,
                              input grant_t typed_grant);
    grant_t g;
    if (!quiet && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    chunk_x <= x;
    chunk_y <= y;
    chunk_z <= z;
    vertex_count <= cnt;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    g = allocate({z, y, x}, cnt);
    pending_grants.push_back(typed ? typed_grant : g);
    accepted_in++;
    @(posedge clk_i);
  endtask

  // Write both registers once the block has gone idle.
  task automatic write_config(input logic [GROW_W-1:0] growth, input logic [CFG_W-1:0] limit);
    in_valid <= 1'b0;
    wait (pending_grants.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_GROWTH_STEP;
    cfg_wdata <= CFG_W'(growth);
    m_growth = growth;
    @(posedge clk_i);
    cfg_idx <= CFG_POOL_LIMIT;
    cfg_wdata <= limit;
    m_limit = limit;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random requests: owners from a small set so ranges get reused and regrown,
  // or fresh keys at fresh_pct; sizes weighted toward interesting classes or up to max_small.
  task automatic random_requests(input int count, input int owners, input int fresh_pct,
                                 input int max_small);
    logic [15:0] kx [32];
    logic [15:0] ky [32];
    logic [15:0] kz [32];
    logic [15:0] x, y, z;
    logic [CNT_W-1:0] cnt;
    int sel, cls;
    for (int i = 0; i < owners; i++) begin
      kx[i] = 16'($urandom);
      ky[i] = 16'($urandom);
      kz[i] = 16'($urandom);
    end
    for (int i = 0; i < count; i++) begin
      quiet = (accepted_in % 400) >= 300;
      if ($urandom_range(99) < fresh_pct) begin
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end else begin
        sel = $urandom_range(owners - 1);
        x = kx[sel];
        y = ky[sel];
        z = kz[sel];
      end
      cls = $urandom_range(99);
      if (max_small > 0)      cnt = CNT_W'($urandom_range(0, max_small));
      else if (cls < 10)      cnt = CNT_W'($urandom_range(0, 64));
      else if (cls < 70)      cnt = CNT_W'($urandom_range(0, 1 << $urandom_range(6, 15)));
      else if (cls < 80)      cnt = CNT_W'(GRAN_MAX);
      else if (cls < 88)      cnt = CNT_W'($urandom_range(GRAN_MAX + 1, 65535));
      else                    cnt = CNT_W'($urandom);
      push_request(x, y, z, cnt, 1'b0, '0);
    end
  endtask

  // Directed plan; typed rows are readable straight from the rules.
  plan_row_t plan [12] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1, 28'd0, 16'd64, ST_NEW,       29'd1048576},
    '{16'h0000, 16'h0000, 16'h0000, 16'd64,    1'b1, 28'd0, 16'd64, ST_REUSED,    29'd1048576},
    '{16'h8000, 16'h7fff, 16'hffff, 16'd65535, 1'b1, 28'd0, 16'd0,  ST_TOO_LARGE, 29'd1048576},
    '{16'h8000, 16'h7fff, 16'hffff, 16'd32769, 1'b1, 28'd0, 16'd0,  ST_TOO_LARGE, 29'd1048576},
    '{16'h8000, 16'h7fff, 16'hffff, 16'd32768, 1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0},
    '{16'h0000, 16'h0000, 16'h0000, 16'd100,   1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0},
    '{16'h0000, 16'h0000, 16'h0000, 16'd1,     1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0},
    '{16'h7fff, 16'h8000, 16'h5555, 16'd65,    1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0},
    '{16'hffff, 16'hffff, 16'hffff, 16'd16384, 1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0},
    '{16'haaaa, 16'h5555, 16'h0001, 16'd63,    1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0},
    '{16'h8000, 16'h7fff, 16'hffff, 16'd1000,  1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0},
    '{16'h7fff, 16'h8000, 16'h5555, 16'd32768, 1'b0, 28'd0, 16'd0,  ST_NEW,       29'd0}
  };

  // Sender: reset, directed plan, then phases at several register settings.
  initial begin
    grant_t tg;
    m_growth = RESET_GROWTH;
    m_limit = RESET_LIMIT;
    m_pool = RESET_POOL;
    m_fcount = 1;
    for (int i = 0; i < FREE_N; i++) begin
      m_fstart[i] = '0;
      m_fend[i] = '0;
    end
    m_fend[0] = END_W'(RESET_GROWTH);
    for (int i = 0; i < OWNER_N; i++) m_ovalid[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) begin
      tg.start = plan[i].start;
      tg.size = plan[i].size;
      tg.idx = {1'b0, plan[i].cnt} + {2'b0, plan[i].cnt[15:1]};
      tg.status = plan[i].status;
      tg.pool = plan[i].pool;
      push_request(plan[i].x, plan[i].y, plan[i].z, plan[i].cnt, plan[i].typed, tg);
    end
    random_requests(180, 16, 15, 0);
    // Tightest settings: the pool already exceeds the limit, so growth fails.
    write_config(25'd32768, 29'd65536);
    random_requests(150, 12, 20, 0);
    // Widest settings; a burst of fresh small owners fills the owner table.
    write_config(25'd16777216, 29'd268435456);
    random_requests(300, 4, 95, 200);
    random_requests(100, 16, 10, 0);
    write_config(25'(1 << $urandom_range(15, 24)), 29'($urandom_range(65536, 268435456)));
    random_requests(100, 8, 20, 0);
    in_valid <= 1'b0;
    wait (pending_grants.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, and quiet stretches.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && accepted_in >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  // Compare each taken grant against the oldest pending one.
  always @(negedge clk_i) begin
    grant_t exp_g;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected grant: start %0d size %0d status %0d", start_pos, range_size, status);
        fail_count++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (start_pos !== exp_g.start) begin
          $error("start_pos: expected %0d, got %0d", exp_g.start, start_pos);
          fail_count++;
        end
        if (range_size !== exp_g.size) begin
          $error("range_size: expected %0d, got %0d", exp_g.size, range_size);
          fail_count++;
        end
        if (index_count !== exp_g.idx) begin
          $error("index_count: expected %0d, got %0d", exp_g.idx, index_count);
          fail_count++;
        end
        if (status !== exp_g.status) begin
          $error("status: expected %0d, got %0d", exp_g.status, status);
          fail_count++;
        end
        if (pool_size !== exp_g.pool) begin
          $error("pool_size: expected %0d, got %0d", exp_g.pool, pool_size);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(negedge clk_i);
      in_fire = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (!rst_ni || in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
